@@ hdl/pls_pkg.sv @@
// Shared types and codes for the positional list store.
package pls_pkg;

	localparam int CMD_W = 3;
	localparam int POS_W = 6;
	localparam int VAL_W = 32;
	localparam int ST_W = 2;
	localparam int OCNT_W = 6;

	localparam logic [CMD_W-1:0] CMD_INS_FRONT = 3'd0;
	localparam logic [CMD_W-1:0] CMD_INS_BACK  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_INS_POS   = 3'd2;
	localparam logic [CMD_W-1:0] CMD_DEL_FRONT = 3'd3;
	localparam logic [CMD_W-1:0] CMD_DEL_BACK  = 3'd4;
	localparam logic [CMD_W-1:0] CMD_DEL_POS   = 3'd5;
	localparam logic [CMD_W-1:0] CMD_DUMP      = 3'd6;

	localparam logic [ST_W-1:0] ST_OK    = 2'd0;
	localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [ST_W-1:0] ST_RANGE = 2'd2;
	localparam logic [ST_W-1:0] ST_FULL  = 2'd3;

	// A dump gives at most this many beats.
	localparam int DUMP_LIMIT = 32;
	localparam int DUMP_IDX_W = $clog2(DUMP_LIMIT);

	typedef struct packed {
		logic                  exec;
		logic                  dump_rd;
		logic                  dump_last;
		logic [DUMP_IDX_W-1:0] dump_idx;
	} pls_ctl_t;

	typedef struct packed {
		logic [DUMP_IDX_W:0] dump_len;
	} pls_stat_t;

endpackage

@@ hdl/pls_ctrl.sv @@
// Controller: command acceptance and the dump sequencer.
module pls_ctrl
	import pls_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [CMD_W-1:0] cmd,
	input  pls_stat_t        stat,
	output pls_ctl_t         ctl,
	output logic             busy
);

	localparam logic S_IDLE = 1'b0;
	localparam logic S_DUMP = 1'b1;

	logic                  state_q;
	logic [DUMP_IDX_W-1:0] ptr_q;
	logic                  accept;
	logic                  ptr_last;

	assign busy = (state_q == S_DUMP);
	assign accept = start && !busy;
	assign ptr_last = ({1'b0, ptr_q} == (stat.dump_len - 1'b1));

	always_comb begin
		ctl.exec = accept;
		ctl.dump_rd = (state_q == S_DUMP);
		ctl.dump_last = ptr_last;
		ctl.dump_idx = ptr_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ptr_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					// first beat leaves with the command; sequence the rest
					if (accept && cmd == CMD_DUMP && stat.dump_len > 1) begin
						state_q <= S_DUMP;
						ptr_q <= DUMP_IDX_W'(1);
					end
				end
				S_DUMP: begin
					ptr_q <= ptr_q + 1'b1;
					if (ptr_last) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

@@ hdl/pls_dpath.sv @@
// Datapath: row of element cells, element count and the result register.
module pls_dpath
	import pls_pkg::*;
#(
	parameter int CAPACITY = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  pls_ctl_t                ctl,
	input  logic [CMD_W-1:0]        cmd,
	input  logic [POS_W-1:0]        position,
	input  logic signed [VAL_W-1:0] item_value,
	output pls_stat_t               stat,
	output logic                    strobe,
	output logic signed [VAL_W-1:0] out_value,
	output logic [ST_W-1:0]         status,
	output logic [OCNT_W-1:0]       count,
	output logic                    last
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int IW = $clog2(CAPACITY);
	localparam int PW = ((CW > POS_W) ? CW : POS_W) + 1;

	logic [VAL_W-1:0] cells_q [CAPACITY];
	logic [CW-1:0]    cnt_q;

	logic             strobe_q;
	logic [VAL_W-1:0] value_q;
	logic [ST_W-1:0]  status_q;
	logic [OCNT_W-1:0] count_q;
	logic             last_q;

	logic [PW-1:0]    pos_e, cnt_e, ins_idx, del_idx, rd_addr_w;
	logic [IW-1:0]    rd_addr;
	logic [VAL_W-1:0] rd_data;
	logic             full, empty, is_ins, is_del, is_dump;
	logic             do_ins, do_del;
	logic [ST_W-1:0]  st;
	logic [CW-1:0]    cnt_d;

	assign pos_e = PW'(position);
	assign cnt_e = PW'(cnt_q);
	assign full = (cnt_q == CW'(CAPACITY));
	assign empty = (cnt_q == '0);
	assign is_ins = (cmd == CMD_INS_FRONT) || (cmd == CMD_INS_BACK) || (cmd == CMD_INS_POS);
	assign is_del = (cmd == CMD_DEL_FRONT) || (cmd == CMD_DEL_BACK) || (cmd == CMD_DEL_POS);
	assign is_dump = (cmd == CMD_DUMP);

	assign stat.dump_len = (cnt_e < PW'(DUMP_LIMIT)) ? (DUMP_IDX_W+1)'(cnt_e)
		: (DUMP_IDX_W+1)'(DUMP_LIMIT);

	always_comb begin
		st = ST_OK;
		do_ins = 1'b0;
		do_del = 1'b0;
		case (cmd)
			CMD_INS_FRONT: ins_idx = '0;
			CMD_INS_BACK:  ins_idx = cnt_e;
			default:       ins_idx = pos_e - 1'b1;
		endcase
		case (cmd)
			CMD_DEL_FRONT: del_idx = '0;
			CMD_DEL_BACK:  del_idx = cnt_e - 1'b1;
			default:       del_idx = pos_e - 1'b1;
		endcase
		if (is_ins) begin
			if (full) begin
				st = ST_FULL;
			end else if (cmd == CMD_INS_POS && (position == '0 || pos_e > cnt_e + 1'b1)) begin
				st = ST_RANGE;
			end else begin
				do_ins = ctl.exec;
			end
		end else if (is_del) begin
			if (empty) begin
				st = ST_EMPTY;
			end else if (cmd == CMD_DEL_POS && (position == '0 || pos_e > cnt_e)) begin
				st = ST_RANGE;
			end else begin
				do_del = ctl.exec;
			end
		end else if (is_dump && empty) begin
			st = ST_EMPTY;
		end
		cnt_d = cnt_q;
		if (do_ins) begin
			cnt_d = cnt_q + 1'b1;
		end else if (do_del) begin
			cnt_d = cnt_q - 1'b1;
		end
	end

	// single read port: dump beats, first dump beat, or the deleted cell
	always_comb begin
		if (ctl.dump_rd) begin
			rd_addr_w = PW'(ctl.dump_idx);
		end else if (is_dump) begin
			rd_addr_w = '0;
		end else begin
			rd_addr_w = del_idx;
		end
	end
	assign rd_addr = rd_addr_w[IW-1:0];
	assign rd_data = cells_q[rd_addr];

	// shift the whole row at once for an insert or a delete
	always_ff @(posedge clk) begin
		for (int i = 0; i < CAPACITY; i++) begin
			if (do_ins) begin
				if (PW'(i) == ins_idx) begin
					cells_q[i] <= item_value;
				end else if (i > 0 && PW'(i) > ins_idx) begin
					cells_q[i] <= cells_q[(i > 0) ? i - 1 : 0];
				end
			end else if (do_del) begin
				if (i < CAPACITY - 1 && PW'(i) >= del_idx) begin
					cells_q[i] <= cells_q[(i < CAPACITY - 1) ? i + 1 : i];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			strobe_q <= 1'b0;
		end else begin
			cnt_q <= cnt_d;
			strobe_q <= ctl.exec || ctl.dump_rd;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.dump_rd) begin
			value_q <= rd_data;
			status_q <= ST_OK;
			count_q <= OCNT_W'(cnt_q);
			last_q <= ctl.dump_last;
		end else if (ctl.exec) begin
			value_q <= (do_del || (is_dump && !empty)) ? rd_data : '0;
			status_q <= st;
			count_q <= OCNT_W'(cnt_d);
			last_q <= !(is_dump && stat.dump_len > 1);
		end
	end

	assign strobe = strobe_q;
	assign out_value = value_q;
	assign status = status_q;
	assign count = count_q;
	assign last = last_q;

`ifndef SYNTHESIS
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctl.exec && ctl.dump_rd))
		else $error("command accepted during a dump");
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(CAPACITY))
		else $error("element count above capacity");
	a_beat_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.exec || ctl.dump_rd) |=> strobe_q)
		else $error("beat missing after load");
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctl.exec || ctl.dump_rd) |=> !strobe_q)
		else $error("beat without load");
	a_dump_idx: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.dump_rd |-> ({1'b0, ctl.dump_idx} < stat.dump_len))
		else $error("dump index past list end");
	a_dump_stable: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.dump_rd |=> $stable(cnt_q))
		else $error("count changed during dump");
`endif

endmodule

@@ hdl/positional_list_store_core.sv @@
// Top level of the positional list store: controller plus datapath.
// Bounded ordered list of signed 32-bit values with insert and delete at the
// front, the back or a 1-based position, and a dump command. A command is
// taken when start is high and busy is low; its result beat appears on the
// output ports, marked by strobe for one cycle, in the cycle after the
// command is taken. Every command but dump gives one beat, so commands may
// be issued back to back. A dump of n elements (n at most 32, one beat if
// the list is empty) gives n beats on consecutive cycles and holds busy high
// while it reads the remaining beats through the single read port of the
// element row. The receiver cannot stall beats and must take each one in
// the cycle it is shown.
module positional_list_store_core
	import pls_pkg::*;
#(
	parameter int CAPACITY = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic [CMD_W-1:0]        cmd,
	input  logic [POS_W-1:0]        position,
	input  logic signed [VAL_W-1:0] item_value,
	output logic                    strobe,
	output logic signed [VAL_W-1:0] out_value,
	output logic [ST_W-1:0]         status,
	output logic [OCNT_W-1:0]       count,
	output logic                    last
);

	pls_ctl_t  ctl;
	pls_stat_t stat;

	pls_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.stat   (stat),
		.ctl    (ctl),
		.busy   (busy)
	);

	pls_dpath #(
		.CAPACITY (CAPACITY)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.cmd        (cmd),
		.position   (position),
		.item_value (item_value),
		.stat       (stat),
		.strobe     (strobe),
		.out_value  (out_value),
		.status     (status),
		.count      (count),
		.last       (last)
	);

endmodule

@@ dv/positional_list_store_core_test.sv @@
// Testbench for positional_list_store_core: queued command driver, beat monitor, list predictor.
`timescale 1ns / 100ps

module positional_list_store_core_test;
	import pls_pkg::*;

	localparam int CAPACITY = 32;
	localparam int RANDOM_ITEMS = 330;
	localparam int QUIET_TAIL = 40;
	localparam int MAX_REPORTS = 10;
	localparam logic [CMD_W-1:0] CMD_UNKNOWN = 3'd7;

	typedef struct {
		logic [CMD_W-1:0]        op;
		logic [POS_W-1:0]        pos;
		logic signed [VAL_W-1:0] val;
		logic                    hold;
	} cmd_req_t;

	typedef struct {
		logic signed [VAL_W-1:0] value;
		logic [ST_W-1:0]         st;
		logic [OCNT_W-1:0]       cnt;
		logic                    fin;
	} list_beat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [CMD_W-1:0] cmd = '0;
	logic [POS_W-1:0] position = '0;
	logic signed [VAL_W-1:0] item_value = '0;
	logic busy;
	logic strobe;
	logic signed [VAL_W-1:0] out_value;
	logic [ST_W-1:0] status;
	logic [OCNT_W-1:0] count;
	logic last;

	cmd_req_t cmd_backlog[$];
	cmd_req_t next_req;
	list_beat_t beats_due[$];
	list_beat_t due_beat;
	logic signed [VAL_W-1:0] list_mem [CAPACITY];
	int list_len = 0;
	int plan_len = 0;
	int gap_left = 0;
	int mismatch_count = 0;

	positional_list_store_core #(.CAPACITY(CAPACITY)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.position(position),
		.item_value(item_value),
		.strobe(strobe),
		.out_value(out_value),
		.status(status),
		.count(count),
		.last(last)
	);

	always #5 clk = ~clk;

	task automatic log_failure(input string what);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS)
			$display("%t: %s", $realtime, what);
	endtask

	task automatic push_beat(input logic signed [VAL_W-1:0] v, input logic [ST_W-1:0] st,
			input logic fin);
		list_beat_t b;
		b.value = v;
		b.st = st;
		b.cnt = OCNT_W'(list_len);
		b.fin = fin;
		beats_due.push_back(b);
	endtask

	// Update the list for one accepted command and queue the beats it gives.
	task automatic apply_list_command(input logic [CMD_W-1:0] op, input logic [POS_W-1:0] pos,
			input logic signed [VAL_W-1:0] val);
		logic signed [VAL_W-1:0] taken;
		logic [ST_W-1:0] st;
		int slot;
		int n;
		int i;
		taken = '0;
		st = ST_OK;
		slot = -1;
		case (op)
			CMD_INS_FRONT, CMD_INS_BACK, CMD_INS_POS: begin
				if (list_len >= CAPACITY)
					st = ST_FULL;
				else if (op == CMD_INS_FRONT)
					slot = 0;
				else if (op == CMD_INS_BACK)
					slot = list_len;
				else if (pos == 0 || pos > list_len + 1)
					st = ST_RANGE;
				else
					slot = pos - 1;
				if (slot >= 0) begin
					for (i = list_len; i > slot; i--)
						list_mem[i] = list_mem[i - 1];
					list_mem[slot] = val;
					list_len++;
				end
				push_beat('0, st, 1'b1);
			end
			CMD_DEL_FRONT, CMD_DEL_BACK, CMD_DEL_POS: begin
				if (list_len == 0)
					st = ST_EMPTY;
				else if (op == CMD_DEL_FRONT)
					slot = 0;
				else if (op == CMD_DEL_BACK)
					slot = list_len - 1;
				else if (pos == 0 || pos > list_len)
					st = ST_RANGE;
				else
					slot = pos - 1;
				if (slot >= 0) begin
					taken = list_mem[slot];
					for (i = slot; i + 1 < list_len; i++)
						list_mem[i] = list_mem[i + 1];
					list_len--;
				end
				push_beat(taken, st, 1'b1);
			end
			CMD_DUMP: begin
				if (list_len == 0) begin
					push_beat('0, ST_EMPTY, 1'b1);
				end else begin
					n = (list_len < DUMP_LIMIT) ? list_len : DUMP_LIMIT;
					for (i = 0; i < n; i++)
						push_beat(list_mem[i], ST_OK, i + 1 == n);
				end
			end
			default: push_beat('0, ST_OK, 1'b1);
		endcase
	endtask

	function automatic logic signed [VAL_W-1:0] pick_value();
		case ($urandom_range(0, 7))
			0: return 32'sh8000_0000;
			1: return 32'sh7fff_ffff;
			2: return '0;
			3: return -1;
			default: return $urandom();
		endcase
	endfunction

	// Mostly a legal position, sometimes anything the port can carry.
	function automatic int pick_pos(input int hi);
		if (hi >= 1 && $urandom_range(0, 9) < 8)
			return $urandom_range(1, hi);
		return $urandom_range(0, 63);
	endfunction

	// Queue a command and track the length the list will have after it.
	task automatic plan(input logic [CMD_W-1:0] op, input int pos,
			input logic signed [VAL_W-1:0] val);
		cmd_req_t r;
		r.op = op;
		r.pos = POS_W'(pos);
		r.val = val;
		r.hold = 1'b0;
		cmd_backlog.push_back(r);
		if (op == CMD_INS_FRONT || op == CMD_INS_BACK || op == CMD_INS_POS) begin
			if (plan_len < CAPACITY
					&& (op != CMD_INS_POS || (r.pos >= 1 && r.pos <= plan_len + 1)))
				plan_len++;
		end else if (op == CMD_DEL_FRONT || op == CMD_DEL_BACK || op == CMD_DEL_POS) begin
			if (plan_len > 0 && (op != CMD_DEL_POS || (r.pos >= 1 && r.pos <= plan_len)))
				plan_len--;
		end
	endtask

	task automatic plan_hold();
		cmd_req_t r;
		r.op = '0;
		r.pos = '0;
		r.val = '0;
		r.hold = 1'b1;
		cmd_backlog.push_back(r);
	endtask

	task automatic plan_insert();
		case ($urandom_range(0, 2))
			0: plan(CMD_INS_FRONT, $urandom_range(0, 63), pick_value());
			1: plan(CMD_INS_BACK, $urandom_range(0, 63), pick_value());
			default: plan(CMD_INS_POS, pick_pos(plan_len + 1), pick_value());
		endcase
	endtask

	task automatic plan_random_op(input int grow_pct);
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 8) begin
			plan(($urandom_range(0, 3) == 0) ? CMD_UNKNOWN : CMD_DUMP,
				$urandom_range(0, 63), pick_value());
		end else if (roll < 8 + grow_pct * 92 / 100) begin
			plan_insert();
		end else begin
			case ($urandom_range(0, 2))
				0: plan(CMD_DEL_FRONT, $urandom_range(0, 63), pick_value());
				1: plan(CMD_DEL_BACK, $urandom_range(0, 63), pick_value());
				default: plan(CMD_DEL_POS, pick_pos(plan_len), pick_value());
			endcase
		end
	endtask

	task automatic build_stimulus();
		int random_left;
		int mode;
		int span;
		logic first;
		// Empty list: every delete and dump, position checks after the empty check.
		plan(CMD_DUMP, 0, 0);
		plan(CMD_DEL_FRONT, 0, 0);
		plan(CMD_DEL_BACK, 63, 0);
		plan(CMD_DEL_POS, 0, 0);
		plan(CMD_INS_POS, 0, 5);
		plan(CMD_INS_POS, 2, 6);
		plan(CMD_INS_POS, 1, 32'sh8000_0000);
		plan(CMD_INS_FRONT, 0, 32'sh7fff_ffff);
		plan(CMD_INS_BACK, 0, -1);
		plan(CMD_INS_BACK, 0, 0);
		plan(CMD_INS_POS, 5, 32'sh1234_5678);
		plan(CMD_INS_POS, 63, 9);
		plan(CMD_DUMP, 0, 0);
		plan(CMD_DEL_POS, 0, 0);
		plan(CMD_DEL_POS, 6, 0);
		plan(CMD_DEL_POS, 63, 0);
		plan(CMD_DEL_POS, 3, 0);
		plan(CMD_DEL_FRONT, 0, 0);
		plan(CMD_DEL_BACK, 0, 0);
		plan(CMD_UNKNOWN, 42, 32'sh5555_aaaa);
		plan(CMD_DUMP, 0, 0);
		plan(CMD_DEL_POS, 2, 0);
		plan_hold();

		random_left = RANDOM_ITEMS;
		first = 1'b1;
		while (random_left > 0) begin
			mode = first ? 3 : $urandom_range(0, 3);
			first = 1'b0;
			if (mode == 3) begin
				// Fill to capacity, then hit the full list from every insert.
				while (plan_len < CAPACITY) begin
					plan_insert();
					random_left--;
				end
				plan(CMD_INS_POS, 0, pick_value());
				plan(CMD_INS_FRONT, 0, pick_value());
				plan(CMD_INS_BACK, 0, pick_value());
				plan(CMD_INS_POS, plan_len + 1, pick_value());
				plan(CMD_DUMP, 0, 0);
				random_left -= 5;
			end else begin
				span = $urandom_range(10, 40);
				repeat (span)
					plan_random_op((mode == 0) ? 75 : (mode == 1) ? 25 : 50);
				random_left -= span;
			end
			if ($urandom_range(0, 3) == 0)
				plan_hold();
		end
	endtask

	// Driver: hold the command while busy, otherwise pick gap, hold-off or next command.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			gap_left = 0;
		end else begin
			if (start && !busy)
				apply_list_command(cmd, position, item_value);
			if (!(start && busy)) begin
				if (gap_left > 0) begin
					gap_left--;
					start <= 1'b0;
				end else if (cmd_backlog.size() != 0 && cmd_backlog[0].hold) begin
					if (beats_due.size() == 0)
						void'(cmd_backlog.pop_front());
					start <= 1'b0;
				end else if (cmd_backlog.size() > QUIET_TAIL && $urandom_range(0, 7) == 0) begin
					gap_left = $urandom_range(0, 4);
					start <= 1'b0;
				end else if (cmd_backlog.size() != 0) begin
					next_req = cmd_backlog.pop_front();
					start <= 1'b1;
					cmd <= next_req.op;
					position <= next_req.pos;
					item_value <= next_req.val;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Monitor: every strobed beat must match the oldest expected one.
	always @(posedge clk) begin
		if (arst_n && strobe === 1'b1) begin
			if (beats_due.size() == 0) begin
				log_failure($sformatf("unexpected beat: value %0d status %0d count %0d last %0b",
					out_value, status, count, last));
			end else begin
				due_beat = beats_due.pop_front();
				if (out_value !== due_beat.value || status !== due_beat.st
						|| count !== due_beat.cnt || last !== due_beat.fin)
					log_failure($sformatf({"beat mismatch: expected value %0d status %0d ",
						"count %0d last %0b, got value %0d status %0d count %0d last %0b"},
						due_beat.value, due_beat.st, due_beat.cnt, due_beat.fin,
						out_value, status, count, last));
			end
		end
	end

	initial begin
		build_stimulus();
		repeat (2) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		while (cmd_backlog.size() != 0 || start || beats_due.size() != 0) begin
			@(posedge clk);
			#1;
		end
		repeat (DUMP_LIMIT + 8) @(posedge clk);
		if (beats_due.size() != 0)
			log_failure($sformatf("%0d expected beats never arrived", beats_due.size()));
		if (mismatch_count == 0)
			$display("positional_list_store_core_test: done, clean");
		else
			$display("positional_list_store_core_test: done, errors");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("positional_list_store_core_test: done, errors");
		$finish;
	end

endmodule

@@ sim.f @@
hdl/pls_pkg.sv
hdl/pls_ctrl.sv
hdl/pls_dpath.sv
hdl/positional_list_store_core.sv
dv/positional_list_store_core_test.sv
